// ===== hdl/ptp_dr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptp_dr_pkg;

  // Message length window in bytes.
  localparam logic [10:0] LEN_MIN = 11'd44;
  localparam logic [10:0] LEN_MAX = 11'd64;

  // Nanoseconds per second, fits in 30 bits.
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  localparam int MAX_CLIENTS_DEFAULT = 16;
  localparam int CLIENT_INDEX_W      = 4;
  localparam int CFG_INDEX_W         = 1;

  localparam logic [1:0] MSG_ANNOUNCE  = 2'd1;
  localparam logic [1:0] MSG_DELAY_REQ = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OWN_DOMAIN   = 1'b0,
    REG_OWN_CLOCK_ID = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_BAD_LENGTH    = 3'd0,
    ST_IGNORED       = 3'd1,
    ST_FOREIGN_MASTER = 3'd2,
    ST_ANSWERED      = 3'd3,
    ST_TABLE_FULL    = 3'd4
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_CTIME,
    S_TDIFF,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SLOT_RD,
    S_CYCLE,
    S_COUNT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [10:0] msg_length;
    logic [1:0]  msg_type;
    logic [7:0]  msg_domain;
    logic [63:0] clock_id;
    logic [31:0] src_addr;
    logic [31:0] ts_seconds;
    logic [31:0] ts_nanoseconds;
    logic [63:0] correction_raw;
    logic [63:0] rx_time;
  } msg_item_t;

  typedef struct packed {
    status_t                   status;
    logic [63:0]               response_time;
    logic [CLIENT_INDEX_W-1:0] client_index;
    logic                      new_client;
    logic [63:0]               client_time;
    logic signed [63:0]        time_diff;
    logic [31:0]               correction_ns;
    logic [63:0]               client_interval;
    logic [31:0]               cycle_count;
    logic                      master_active;
  } result_item_t;

  // Write strobes from the sequencer to the client store.
  typedef struct packed {
    logic addr;
    logic stats;
  } store_we_t;

endpackage

`default_nettype wire

// ===== hdl/ptp_dr_msg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ptp_dr_msg_if;
  import ptp_dr_pkg::*;

  logic      valid;
  logic      ready;
  msg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ptp_dr_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ptp_dr_result_if;
  import ptp_dr_pkg::*;

  logic         valid;
  logic         ready;
  result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ptp_dr_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ptp_dr_cfg_if;
  import ptp_dr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [63:0]            data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ptp_delay_request_responder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A rejected, ignored or announce word goes straight from the check step to its result; an
// answered delay request first walks the table entries (at most MAX_CLIENT_ENTRIES), comparing
// each through the shared adder, and a request that finds the table full walks all
// MAX_CLIENT_ENTRIES entries. A new word is taken only once the previous result is
// registered. Reset (rst, synchronous) makes the master active, empties the client table and
// clears both registers.

module ptp_delay_request_responder #(
  parameter int MAX_CLIENT_ENTRIES = ptp_dr_pkg::MAX_CLIENTS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  ptp_dr_msg_if.sink             msg,
  ptp_dr_result_if.source        result,
  ptp_dr_cfg_if.sink             cfg
);
  import ptp_dr_pkg::*;

  // Slot index width and a count width that can also hold the full depth.
  localparam int IDX_W = (MAX_CLIENT_ENTRIES > 1) ? $clog2(MAX_CLIENT_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_CLIENT_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_CLIENT_ENTRIES);

  // Configuration registers.
  logic [7:0]  own_domain;
  logic [63:0] own_clock_id;

  // Persistent block state.
  logic             master_active;
  logic [CNT_W-1:0] client_count;

  // Sequencer and working registers for the word in hand.
  state_t           state;
  state_t           state_next;
  msg_item_t        item;
  result_item_t     res;
  result_item_t     res_init;
  result_item_t     res_final;
  logic [63:0]      product;
  logic [IDX_W-1:0] scan_ptr;
  logic [IDX_W-1:0] slot;
  logic             new_flag;

  // Output register, which lets the sequencer take the next word while a result waits.
  logic         result_valid;
  result_item_t result_q;

  // Shared arithmetic unit and client store connections.
  alu_op_t     alu_op;
  logic [63:0] alu_a;
  logic [63:0] alu_b;
  logic [63:0] alu_sum;
  logic        alu_zero;

  store_we_t        store_we;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_address;
  logic [63:0]      rd_last_seen;
  logic [31:0]      rd_requests;

  logic load_ok;
  logic table_full;
  logic scan_last;
  logic length_bad;

  assign msg.ready    = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign result.valid = result_valid;
  assign result.data  = result_q;

  assign load_ok    = !result_valid || result.ready;
  assign table_full = (client_count == CNT_FULL);
  // The slot just compared is the last one that holds a client.
  assign scan_last  = ((CNT_W'(scan_ptr) + CNT_W'(1)) == client_count);
  assign length_bad = (item.msg_length < LEN_MIN) || (item.msg_length > LEN_MAX);

  ptp_dr_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .sum  (alu_sum),
    .zero (alu_zero)
  );

  ptp_dr_store #(
    .DEPTH (MAX_CLIENT_ENTRIES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk          (clk),
    .we           (store_we),
    .wr_idx       (slot),
    .wr_address   (item.src_addr),
    .wr_last_seen (item.rx_time),
    .wr_requests  (alu_sum[31:0]),
    .rd_idx       (rd_idx),
    .rd_address   (rd_address),
    .rd_last_seen (rd_last_seen),
    .rd_requests  (rd_requests)
  );

  // Configuration writes are only expected while the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_domain   <= 8'd0;
      own_clock_id <= 64'd0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_OWN_DOMAIN:   own_domain   <= cfg.data[7:0];
        REG_OWN_CLOCK_ID: own_clock_id <= cfg.data;
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (msg.valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!length_bad && master_active && item.msg_type == MSG_DELAY_REQ &&
            item.msg_domain == own_domain) begin
          state_next = S_MUL;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MUL:   state_next = S_CTIME;
      S_CTIME: state_next = S_TDIFF;
      S_TDIFF: begin
        if (client_count != '0) begin
          state_next = S_SCAN_RD;
        end else if (table_full) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SLOT_RD;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (alu_zero) begin
          state_next = S_SLOT_RD;
        end else if (!scan_last) begin
          state_next = S_SCAN_RD;
        end else if (table_full) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SLOT_RD;
        end
      end
      S_SLOT_RD: state_next = S_CYCLE;
      S_CYCLE:   state_next = S_COUNT;
      S_COUNT:   state_next = S_FINISH;
      S_FINISH: begin
        if (load_ok) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Operand selection for the shared adder and strobes for the client store.
  always_comb begin
    alu_op   = ALU_ADD;
    alu_a    = 64'd0;
    alu_b    = 64'd0;
    rd_idx   = slot;
    store_we = '0;
    case (state)
      S_CTIME: begin
        alu_a = product;
        alu_b = {32'd0, item.ts_nanoseconds};
      end
      S_TDIFF: begin
        alu_op = ALU_SUB;
        alu_a  = item.rx_time;
        alu_b  = res.client_time;
      end
      S_SCAN_RD: begin
        rd_idx = scan_ptr;
      end
      S_SCAN_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = {32'd0, item.src_addr};
        alu_b  = {32'd0, rd_address};
      end
      S_CYCLE: begin
        // A newly added client has never been seen, so its previous time is zero.
        alu_op = ALU_SUB;
        alu_a  = item.rx_time;
        alu_b  = new_flag ? 64'd0 : rd_last_seen;
      end
      S_COUNT: begin
        alu_a          = new_flag ? 64'd0 : {32'd0, rd_requests};
        alu_b          = 64'd1;
        store_we.stats = 1'b1;
        store_we.addr  = new_flag;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath and persistent state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      master_active <= 1'b1;
      client_count  <= '0;
    end else begin
      if (state == S_CHECK && !length_bad && master_active &&
          item.msg_type == MSG_ANNOUNCE && item.msg_domain == own_domain &&
          item.clock_id != own_clock_id) begin
        master_active <= 1'b0;
      end
      if (state == S_COUNT && new_flag) begin
        client_count <= client_count + CNT_W'(1);
      end
    end
  end

  // Status settled at the check step; fields that do not apply to it stay zero.
  always_comb begin
    res_init = '0;
    if (length_bad) begin
      res_init.status = ST_BAD_LENGTH;
    end else if (master_active && item.msg_type == MSG_ANNOUNCE &&
                 item.msg_domain == own_domain && item.clock_id != own_clock_id) begin
      res_init.status = ST_FOREIGN_MASTER;
    end else begin
      res_init.status = ST_IGNORED;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && msg.valid) begin
      item <= msg.data;
    end
    case (state)
      S_CHECK: begin
        res <= res_init;
      end
      S_MUL: begin
        product           <= 64'(item.ts_seconds) * 64'(NS_PER_SEC);
        res.response_time <= item.rx_time;
        res.correction_ns <= item.correction_raw[47:16];
      end
      S_CTIME: begin
        res.client_time <= alu_sum;
      end
      S_TDIFF: begin
        res.time_diff <= alu_sum;
        scan_ptr      <= '0;
        if (client_count == '0) begin
          if (table_full) begin
            res.status <= ST_TABLE_FULL;
          end else begin
            slot     <= IDX_W'(client_count);
            new_flag <= 1'b1;
          end
        end
      end
      S_SCAN_CMP: begin
        if (alu_zero) begin
          slot     <= scan_ptr;
          new_flag <= 1'b0;
        end else if (!scan_last) begin
          scan_ptr <= scan_ptr + IDX_W'(1);
        end else if (table_full) begin
          res.status <= ST_TABLE_FULL;
        end else begin
          slot     <= IDX_W'(client_count);
          new_flag <= 1'b1;
        end
      end
      S_CYCLE: begin
        res.client_interval <= alu_sum;
      end
      S_COUNT: begin
        res.cycle_count  <= alu_sum[31:0];
        res.client_index <= CLIENT_INDEX_W'(slot);
        res.new_client   <= new_flag;
        res.status       <= ST_ANSWERED;
      end
      default: ;
    endcase
  end

  // The finished result carries the master state after this word.
  always_comb begin
    res_final               = res;
    res_final.master_active = master_active;
  end

  // Output register: holds a result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result.ready) begin
        result_valid <= 1'b0;
      end
      if (state == S_FINISH && load_ok) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && load_ok) begin
      result_q <= res_final;
    end
  end

  // The table never grows beyond its depth.
  assert property (@(posedge clk) disable iff (rst) client_count <= CNT_FULL)
    else $error("client count exceeds table depth");

  // A new client is only written while a free slot remains.
  assert property (@(posedge clk) disable iff (rst) store_we.addr |-> !table_full)
    else $error("client added to a full table");

  // An accepted word always starts the sequencer.
  assert property (@(posedge clk) disable iff (rst) msg.valid && msg.ready |=> state == S_CHECK)
    else $error("accepted word did not start processing");

  // Delay requests are only answered by an active master.
  assert property (@(posedge clk) disable iff (rst)
      result.valid && (result.data.status == ST_ANSWERED ||
                       result.data.status == ST_TABLE_FULL) |-> result.data.master_active)
    else $error("answer given by an inactive master");

endmodule

`default_nettype wire

// ===== hdl/ptp_dr_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared 64-bit adder and subtractor with a zero flag on the result.
module ptp_dr_alu (
  input  ptp_dr_pkg::alu_op_t op,
  input  logic [63:0]         a,
  input  logic [63:0]         b,
  output logic [63:0]         sum,
  output logic                zero
);
  import ptp_dr_pkg::*;

  always_comb begin
    case (op)
      ALU_ADD: sum = a + b;
      ALU_SUB: sum = a - b;
      default: sum = a + b;
    endcase
  end

  assign zero = (sum == 64'd0);

endmodule

`default_nettype wire

// ===== hdl/ptp_dr_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Client table: address, last receive time and request count per slot.
// One write address and one registered read address per cycle.
module ptp_dr_store #(
  parameter int DEPTH = ptp_dr_pkg::MAX_CLIENTS_DEFAULT,
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  ptp_dr_pkg::store_we_t we,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [31:0]           wr_address,
  input  logic [63:0]           wr_last_seen,
  input  logic [31:0]           wr_requests,
  input  logic [IDX_W-1:0]      rd_idx,
  output logic [31:0]           rd_address,
  output logic [63:0]           rd_last_seen,
  output logic [31:0]           rd_requests
);
  import ptp_dr_pkg::*;

  logic [31:0] address_mem   [DEPTH];
  logic [63:0] last_seen_mem [DEPTH];
  logic [31:0] requests_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we.addr) begin
      address_mem[wr_idx] <= wr_address;
    end
    if (we.stats) begin
      last_seen_mem[wr_idx] <= wr_last_seen;
      requests_mem[wr_idx]  <= wr_requests;
    end
  end

  always_ff @(posedge clk) begin
    rd_address   <= address_mem[rd_idx];
    rd_last_seen <= last_seen_mem[rd_idx];
    rd_requests  <= requests_mem[rd_idx];
  end

endmodule

`default_nettype wire

// ===== test/ptp_delay_request_responder_test.sv =====
`timescale 1ns / 1ps

module ptp_delay_request_responder_test;
  import ptp_dr_pkg::*;

  // Message types that the package leaves unnamed; the block ignores both.
  localparam logic [1:0] MSG_OTHER    = 2'd0;
  localparam logic [1:0] MSG_RESERVED = 2'd3;

  localparam int          TABLE_DEPTH = MAX_CLIENTS_DEFAULT;
  localparam int          POOL_SIZE   = 20;
  localparam logic [63:0] NS_PER_S    = 64'd1000000000;

  logic clk = 1'b0;
  logic rst;

  ptp_dr_msg_if    msg_ch ();
  ptp_dr_result_if reply_ch ();
  ptp_dr_cfg_if    cfg_ch ();

  ptp_delay_request_responder u_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .result (reply_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // Our own picture of the master: its configuration, whether it is still active,
  // and the client table with the receive time and request count of each client.
  logic [7:0]  mirror_domain;
  logic [63:0] mirror_clock_id;
  logic        mirror_active;
  int          mirror_clients;
  logic [31:0] peer_addr [TABLE_DEPTH];
  logic [63:0] peer_last_rx [TABLE_DEPTH];
  logic [31:0] peer_requests [TABLE_DEPTH];

  // Replies that the block owes us, oldest first.
  result_item_t pending_replies [$];

  // Addresses that the random traffic draws its clients from. The pool is larger
  // than the table, so the later traffic runs into a full table.
  logic [31:0] client_pool [POOL_SIZE];

  int unsigned sender_idle_pct;
  int unsigned reader_idle_pct;
  int unsigned hold_cycles;
  int          errors;

  // Works out the reply to one accepted message word and moves the mirrored state on.
  // Fields that do not belong to the status stay at zero.
  function automatic result_item_t answer_message(input msg_item_t m);
    result_item_t r;
    logic [63:0]  sent_ns;
    int           slot;
    logic         added;
    r = '0;
    r.status = ST_IGNORED;
    if (m.msg_length < LEN_MIN || m.msg_length > LEN_MAX) begin
      // The length check comes first, even for a master that has gone quiet.
      r.status = ST_BAD_LENGTH;
    end else if (!mirror_active) begin
      r.status = ST_IGNORED;
    end else if (m.msg_type == MSG_ANNOUNCE) begin
      // Another master in our domain: we stand down for good.
      if (m.msg_domain == mirror_domain && m.clock_id != mirror_clock_id) begin
        mirror_active = 1'b0;
        r.status = ST_FOREIGN_MASTER;
      end
    end else if (m.msg_type == MSG_DELAY_REQ && m.msg_domain == mirror_domain) begin
      sent_ns = 64'(m.ts_seconds) * NS_PER_S + 64'(m.ts_nanoseconds);
      r.response_time = m.rx_time;
      r.client_time   = sent_ns;
      r.time_diff     = m.rx_time - sent_ns;
      r.correction_ns = m.correction_raw[47:16];
      slot  = -1;
      added = 1'b0;
      for (int k = 0; k < mirror_clients; k++) begin
        if (slot < 0 && peer_addr[k] == m.src_addr) slot = k;
      end
      if (slot < 0 && mirror_clients < TABLE_DEPTH) begin
        slot = mirror_clients;
        peer_addr[slot] = m.src_addr;
        mirror_clients++;
        added = 1'b1;
      end
      if (slot >= 0) begin
        r.client_index    = CLIENT_INDEX_W'(slot);
        r.new_client      = added;
        r.client_interval = m.rx_time - peer_last_rx[slot];
        peer_last_rx[slot]  = m.rx_time;
        peer_requests[slot] = peer_requests[slot] + 32'd1;
        r.cycle_count  = peer_requests[slot];
        r.status       = ST_ANSWERED;
      end else begin
        // Still answered, but the unknown client cannot be entered in the table.
        r.status = ST_TABLE_FULL;
      end
    end
    r.master_active = mirror_active;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want, got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // A well-formed delay request from the given address with random content.
  function automatic msg_item_t plain_request(input logic [31:0] addr);
    msg_item_t m;
    m.msg_length     = 11'($urandom_range(LEN_MAX, LEN_MIN));
    m.msg_type       = MSG_DELAY_REQ;
    m.msg_domain     = mirror_domain;
    m.clock_id       = {$urandom, $urandom};
    m.src_addr       = addr;
    m.ts_seconds     = $urandom;
    m.ts_nanoseconds = $urandom;
    m.correction_raw = {$urandom, $urandom};
    m.rx_time        = {$urandom, $urandom};
    return m;
  endfunction

  // Mostly well-formed delay requests from the first pool_used clients; the rest is
  // noise: odd lengths, other types, other domains and harmless announces.
  function automatic msg_item_t random_message(input int pool_used, output bit regular);
    msg_item_t   m;
    int unsigned pick;
    m = plain_request(client_pool[$urandom_range(pool_used - 1)]);
    pick = $urandom_range(99);
    regular = 1'b0;
    if (pick < 6) begin
      m.msg_length = 11'($urandom_range(2047));
    end else if (pick < 10) begin
      m.msg_type = 2'($urandom_range(3));
    end else if (pick < 14) begin
      m.msg_domain = mirror_domain ^ 8'($urandom_range(255, 1));
    end else if (pick < 17) begin
      m.msg_type = MSG_ANNOUNCE;
      m.clock_id = mirror_clock_id;
    end else if (pick < 20) begin
      m.msg_type   = MSG_ANNOUNCE;
      m.msg_domain = mirror_domain ^ 8'($urandom_range(255, 1));
    end else begin
      regular = 1'b1;
    end
    // A foreign announce in our own domain would silence the master for the rest of
    // the run, so that case is left to the last test.
    if (m.msg_type == MSG_ANNOUNCE && m.msg_domain == mirror_domain) begin
      m.clock_id = mirror_clock_id;
    end
    return m;
  endfunction

  // Offers one message word, with random idle cycles in front of it when the
  // current mode asks for them. Valid stays high on return, so that back-to-back
  // words go out without a gap; it is lowered only by an idle cycle or a drain.
  task automatic send_word(input msg_item_t m);
    while ($urandom_range(99) < sender_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.data  <= m;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    pending_replies.push_back(answer_message(m));
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_OWN_DOMAIN: begin
        mirror_domain = value[7:0];
      end
      REG_OWN_CLOCK_ID: begin
        mirror_clock_id = value;
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_master(input logic [7:0] domain, input logic [63:0] clock_id);
    write_reg(REG_OWN_DOMAIN, 64'(domain));
    write_reg(REG_OWN_CLOCK_ID, clock_id);
  endtask

  // Every message word gives exactly one reply, so once nothing is owed the block
  // is idle; a few spare cycles follow for good measure.
  task automatic drain_replies();
    msg_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random traffic until n_regular well-formed delay requests have gone out.
  task automatic run_traffic(input int n_regular, input int pool_used);
    msg_item_t m;
    bit        regular;
    int        sent;
    sent = 0;
    while (sent < n_regular) begin
      m = random_message(pool_used, regular);
      send_word(m);
      if (regular) sent++;
    end
  endtask

  // Lengths on both sides of the 44 to 64 byte window, and the field's extremes.
  task automatic test_length_window();
    logic [10:0] lengths [6] = '{11'd0, 11'd43, 11'd44, 11'd64, 11'd65, 11'd2047};
    msg_item_t   m;
    foreach (lengths[i]) begin
      m = plain_request(32'h0A00_0001);
      m.msg_length = lengths[i];
      send_word(m);
    end
  endtask

  // Messages that an active master lets pass without an answer.
  task automatic test_ignored_messages();
    msg_item_t m;
    m = plain_request(32'h0A00_0002);
    m.msg_type = MSG_OTHER;
    send_word(m);
    m = plain_request(32'h0A00_0002);
    m.msg_type = MSG_RESERVED;
    send_word(m);
    // Our own announce coming back to us.
    m = plain_request(32'h0A00_0002);
    m.msg_type = MSG_ANNOUNCE;
    m.clock_id = mirror_clock_id;
    send_word(m);
    // A foreign announce, but for another domain.
    m = plain_request(32'h0A00_0002);
    m.msg_type   = MSG_ANNOUNCE;
    m.msg_domain = mirror_domain ^ 8'h80;
    send_word(m);
    // A delay request for another domain.
    m = plain_request(32'h0A00_0002);
    m.msg_domain = mirror_domain ^ 8'h01;
    send_word(m);
  endtask

  // All-zero and all-one timestamps, corrections and addresses, and a second
  // request from the same client whose receive time wraps backwards.
  task automatic test_field_extremes();
    msg_item_t m;
    m = plain_request(32'h0000_0000);
    m.clock_id       = '0;
    m.ts_seconds     = '0;
    m.ts_nanoseconds = '0;
    m.correction_raw = '0;
    m.rx_time        = '0;
    send_word(m);
    m = plain_request(32'hFFFF_FFFF);
    m.clock_id       = '1;
    m.ts_seconds     = '1;
    m.ts_nanoseconds = '1;
    m.correction_raw = '1;
    m.rx_time        = '1;
    send_word(m);
    m = plain_request(32'hFFFF_FFFF);
    m.rx_time = 64'd5;
    send_word(m);
  endtask

  // Several configurations, each with its own idle pattern. The client pool grows
  // from phase to phase, so the last phase fills the table and goes past it.
  task automatic test_config_sweep();
    drain_replies();
    program_master(8'hFF, '1);
    sender_idle_pct = 9;
    reader_idle_pct = 66;
    run_traffic(90, 8);

    drain_replies();
    program_master(8'h00, '0);
    sender_idle_pct = 66;
    reader_idle_pct = 9;
    run_traffic(90, 12);

    drain_replies();
    program_master(8'($urandom), {$urandom, $urandom});
    sender_idle_pct = 0;
    reader_idle_pct = 0;
    run_traffic(90, POOL_SIZE);
  endtask

  // The reader holds off for a long stretch while words keep coming, so that the
  // block fills up and has to stall its input.
  task automatic test_output_backpressure();
    drain_replies();
    sender_idle_pct = 0;
    reader_idle_pct = 0;
    @(posedge clk);
    hold_cycles = 300;
    @(negedge clk);
    run_traffic(30, POOL_SIZE);
  endtask

  // Another master shows up in our domain. This runs last, since the master never
  // comes back to life short of a reset.
  task automatic test_foreign_master();
    msg_item_t m;
    drain_replies();
    // A bad length is rejected before the announce is even looked at.
    m = plain_request(32'h0A00_0003);
    m.msg_type   = MSG_ANNOUNCE;
    m.clock_id   = ~mirror_clock_id;
    m.msg_length = LEN_MIN - 11'd1;
    send_word(m);
    m.msg_length = 11'd50;
    send_word(m);
    // From here on everything is ignored, apart from bad lengths.
    m = plain_request(client_pool[0]);
    send_word(m);
    m = plain_request(32'h0A00_0003);
    m.msg_type = MSG_ANNOUNCE;
    m.clock_id = ~mirror_clock_id;
    send_word(m);
    m = plain_request(client_pool[1]);
    m.msg_length = LEN_MAX + 11'd1;
    send_word(m);
  endtask

  // The reader's ready, redrawn every cycle, or held low while a hold-off is counting.
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      reply_ch.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      reply_ch.ready <= ($urandom_range(99) >= reader_idle_pct);
    end
  end

  // Each reply word is compared, field by field, with the oldest one owed.
  always @(posedge clk) begin : check_replies
    result_item_t want;
    result_item_t got;
    if (!rst && reply_ch.valid && reply_ch.ready) begin
      got = reply_ch.data;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: reply expected none, got status %0d", $time, got.status);
      end else begin
        want = pending_replies.pop_front();
        check_field("status", want.status, got.status);
        check_field("response_time", want.response_time, got.response_time);
        check_field("client_index", want.client_index, got.client_index);
        check_field("new_client", want.new_client, got.new_client);
        check_field("client_time", want.client_time, got.client_time);
        check_field("time_diff", want.time_diff, got.time_diff);
        check_field("correction_ns", want.correction_ns, got.correction_ns);
        check_field("client_interval", want.client_interval, got.client_interval);
        check_field("cycle_count", want.cycle_count, got.cycle_count);
        check_field("master_active", want.master_active, got.master_active);
      end
    end
  end

  initial begin
    rst            = 1'b1;
    msg_ch.valid   = 1'b0;
    msg_ch.data    = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_OWN_DOMAIN;
    cfg_ch.data    = '0;
    reply_ch.ready = 1'b0;
    errors          = 0;
    hold_cycles     = 0;
    sender_idle_pct = 0;
    reader_idle_pct = 0;

    // State after reset: active, empty table, both registers zero.
    mirror_domain   = '0;
    mirror_clock_id = '0;
    mirror_active   = 1'b1;
    mirror_clients  = 0;
    foreach (peer_addr[i]) begin
      peer_addr[i]     = '0;
      peer_last_rx[i]  = '0;
      peer_requests[i] = '0;
    end
    // The low five bits keep the pool addresses apart; the rest is random.
    foreach (client_pool[i]) begin
      client_pool[i] = ($urandom & 32'hFFFF_FFE0) | 32'(i);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    program_master(8'h2C, 64'h0123_4567_89AB_CDEF);
    test_length_window();
    test_ignored_messages();
    test_field_extremes();
    test_config_sweep();
    test_output_backpressure();
    test_foreign_master();

    // Let any stray reply word turn up before the verdict.
    drain_replies();
    repeat (40) @(posedge clk);
    if (pending_replies.size() != 0) begin
      errors++;
      $display("%0t: %0d replies never arrived", $time, pending_replies.size());
    end
    if (errors == 0) begin
      $display("ptp_delay_request_responder_test OK");
    end else begin
      $display("ptp_delay_request_responder_test NOT OK");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this.
  initial begin
    #5_000_000;
    $display("ptp_delay_request_responder_test NOT OK");
    $finish;
  end

endmodule
